// ===== sv/ssuvr_pkg.sv =====
package ssuvr_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int COLOR_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_EN = 3'd0,
    CFG_LO_X    = 3'd1,
    CFG_LO_Y    = 3'd2,
    CFG_HI_X    = 3'd3,
    CFG_HI_Y    = 3'd4
  } cfg_idx_t;

endpackage

// ===== sv/ssuvr_div.sv =====
module ssuvr_div #(
  parameter int NB = 33,
  parameter int DB = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output logic [NB-1:0] quo
);

  logic [DB-1:0] rem_r [NB];
  logic [NB-1:0] nq_r  [NB];
  logic [DB-1:0] den_r [NB];
  logic [DB-1:0] rem_nxt [NB];
  logic [NB-1:0] nq_nxt  [NB];

  always_comb begin
    logic [DB-1:0] rin;
    logic [NB-1:0] nin;
    logic [DB-1:0] din;
    logic [DB:0]   t;
    logic          ge;
    for (int i = 0; i < NB; i++) begin
      if (i == 0) begin
        rin = '0;
        nin = num;
        din = den;
      end else begin
        rin = rem_r[i-1];
        nin = nq_r[i-1];
        din = den_r[i-1];
      end
      t  = {rin, nin[NB-1]};
      ge = (t >= {1'b0, din});
      rem_nxt[i] = ge ? DB'(t - {1'b0, din}) : t[DB-1:0];
      nq_nxt[i]  = {nin[NB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      for (int i = 0; i < NB; i++) begin
        rem_r[i] <= rem_nxt[i];
        nq_r[i]  <= nq_nxt[i];
      end
      for (int i = 1; i < NB; i++) begin
        den_r[i] <= den_r[i-1];
      end
    end
  end

  assign quo = nq_r[NB-1];

endmodule

// ===== sv/sprite_scissor_uv_remap_core.sv =====
// Throughput: one word per cycle when not stalled; the restoring divider keeps one quotient bit per stage.
// The whole pipeline holds while a result waits under out_stall.
// Reset (rst_n low, synchronous) clears all valid bits and the clip registers to 0.
module sprite_scissor_uv_remap_core #(
  parameter int COORD_BITS   = 16,
  parameter int UV_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ssuvr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_pos_left,
  input  logic signed [COORD_BITS-1:0]        in_pos_top,
  input  logic signed [COORD_BITS-1:0]        in_pos_right,
  input  logic signed [COORD_BITS-1:0]        in_pos_bottom,
  input  logic [UV_FRAC_BITS:0]               in_tex_u0,
  input  logic [UV_FRAC_BITS:0]               in_tex_v0,
  input  logic [UV_FRAC_BITS:0]               in_tex_u1,
  input  logic [UV_FRAC_BITS:0]               in_tex_v1,
  input  logic                                in_rotated,
  input  logic [ssuvr_pkg::COLOR_W-1:0]       in_color,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_skipped,
  output logic signed [COORD_BITS-1:0]        out_left,
  output logic signed [COORD_BITS-1:0]        out_top,
  output logic signed [COORD_BITS-1:0]        out_right,
  output logic signed [COORD_BITS-1:0]        out_bottom,
  output logic [UV_FRAC_BITS:0]               out_u0,
  output logic [UV_FRAC_BITS:0]               out_v0,
  output logic [UV_FRAC_BITS:0]               out_u1,
  output logic [UV_FRAC_BITS:0]               out_v1,
  output logic                                out_rotated,
  output logic [ssuvr_pkg::COLOR_W-1:0]       out_color
);

  localparam int CB = COORD_BITS;
  localparam int FB = UV_FRAC_BITS;
  localparam int NB = CB + FB + 1;
  localparam int PW = CB + FB + 3;
  localparam int SW = NB + 2;

  typedef struct packed {
    logic                     vld;
    logic                     skip;
    logic                     clip;
    logic                     rot;
    logic [ssuvr_pkg::COLOR_W-1:0] color;
    logic signed [CB-1:0]     l;
    logic signed [CB-1:0]     t;
    logic signed [CB-1:0]     r;
    logic signed [CB-1:0]     b;
    logic [FB:0]              u0;
    logic [FB:0]              v0;
    logic [FB:0]              u1;
    logic [FB:0]              v1;
    logic [FB:0]              bx;
    logic [FB:0]              by;
    logic [3:0]               neg;
  } side_t;

  logic clip_en_r;
  logic signed [CB-1:0] lo_x_r, lo_y_r, hi_x_r, hi_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_en_r <= 1'b0;
      lo_x_r    <= '0;
      lo_y_r    <= '0;
      hi_x_r    <= '0;
      hi_y_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssuvr_pkg::CFG_CLIP_EN: clip_en_r <= cfg_wdata[0];
        ssuvr_pkg::CFG_LO_X:    lo_x_r    <= cfg_wdata;
        ssuvr_pkg::CFG_LO_Y:    lo_y_r    <= cfg_wdata;
        ssuvr_pkg::CFG_HI_X:    hi_x_r    <= cfg_wdata;
        ssuvr_pkg::CFG_HI_Y:    hi_y_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage 1: reject test, clamp, offsets
  side_t s1_r, s1_nxt;
  logic signed [CB:0]   s1_off_r [4];
  logic signed [CB:0]   s1_off_nxt [4];
  logic signed [FB+1:0] s1_spx_r, s1_spy_r, s1_spx_nxt, s1_spy_nxt;
  logic [CB-1:0]        s1_w_r, s1_h_r;
  logic signed [CB:0]   w_c, h_c;

  always_comb begin
    logic signed [CB-1:0] cl, cr, ct, cb;
    logic signed [FB+1:0] du, dv;
    w_c = {in_pos_right[CB-1], in_pos_right} - {in_pos_left[CB-1], in_pos_left};
    h_c = {in_pos_bottom[CB-1], in_pos_bottom} - {in_pos_top[CB-1], in_pos_top};
    cl = (in_pos_left > lo_x_r) ? in_pos_left : lo_x_r;
    cr = (in_pos_right < hi_x_r) ? in_pos_right : hi_x_r;
    ct = (in_pos_top > lo_y_r) ? in_pos_top : lo_y_r;
    cb = (in_pos_bottom < hi_y_r) ? in_pos_bottom : hi_y_r;
    du = $signed({1'b0, in_tex_u1}) - $signed({1'b0, in_tex_u0});
    dv = $signed({1'b0, in_tex_v1}) - $signed({1'b0, in_tex_v0});
    s1_nxt.vld   = in_valid;
    s1_nxt.clip  = clip_en_r;
    s1_nxt.skip  = clip_en_r && (in_pos_right <= lo_x_r || in_pos_bottom <= lo_y_r ||
                                 w_c <= 0 || h_c <= 0);
    s1_nxt.rot   = in_rotated;
    s1_nxt.color = in_color;
    s1_nxt.l     = clip_en_r ? cl : in_pos_left;
    s1_nxt.r     = clip_en_r ? cr : in_pos_right;
    s1_nxt.t     = clip_en_r ? ct : in_pos_top;
    s1_nxt.b     = clip_en_r ? cb : in_pos_bottom;
    s1_nxt.u0    = in_tex_u0;
    s1_nxt.v0    = in_tex_v0;
    s1_nxt.u1    = in_tex_u1;
    s1_nxt.v1    = in_tex_v1;
    s1_nxt.bx    = in_rotated ? in_tex_v0 : in_tex_u0;
    s1_nxt.by    = in_rotated ? in_tex_u0 : in_tex_v0;
    s1_nxt.neg   = '0;
    s1_off_nxt[0] = {cl[CB-1], cl} - {in_pos_left[CB-1], in_pos_left};
    s1_off_nxt[1] = {cr[CB-1], cr} - {in_pos_left[CB-1], in_pos_left};
    s1_off_nxt[2] = {ct[CB-1], ct} - {in_pos_top[CB-1], in_pos_top};
    s1_off_nxt[3] = {cb[CB-1], cb} - {in_pos_top[CB-1], in_pos_top};
    s1_spx_nxt = in_rotated ? dv : du;
    s1_spy_nxt = in_rotated ? du : dv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (adv) begin
      s1_r.vld <= s1_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.skip  <= s1_nxt.skip;
      s1_r.clip  <= s1_nxt.clip;
      s1_r.rot   <= s1_nxt.rot;
      s1_r.color <= s1_nxt.color;
      s1_r.l     <= s1_nxt.l;
      s1_r.t     <= s1_nxt.t;
      s1_r.r     <= s1_nxt.r;
      s1_r.b     <= s1_nxt.b;
      s1_r.u0    <= s1_nxt.u0;
      s1_r.v0    <= s1_nxt.v0;
      s1_r.u1    <= s1_nxt.u1;
      s1_r.v1    <= s1_nxt.v1;
      s1_r.bx    <= s1_nxt.bx;
      s1_r.by    <= s1_nxt.by;
      s1_r.neg   <= s1_nxt.neg;
      s1_off_r   <= s1_off_nxt;
      s1_spx_r   <= s1_spx_nxt;
      s1_spy_r   <= s1_spy_nxt;
      s1_w_r     <= w_c[CB-1:0];
      s1_h_r     <= h_c[CB-1:0];
    end
  end

  // stage 2: products, split into sign and magnitude
  side_t s2_r, s2_nxt;
  logic [NB-1:0] s2_mag_r [4];
  logic [NB-1:0] s2_mag_nxt [4];
  logic [CB-1:0] s2_w_r, s2_h_r;

  always_comb begin
    logic signed [PW-1:0] p;
    logic [PW-1:0]        m;
    s2_nxt = s1_r;
    for (int k = 0; k < 4; k++) begin
      p = PW'(s1_off_r[k]) * PW'((k < 2) ? s1_spx_r : s1_spy_r);
      m = p[PW-1] ? PW'(-p) : PW'(p);
      s2_nxt.neg[k] = p[PW-1];
      s2_mag_nxt[k] = m[NB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else if (adv) begin
      s2_r.vld <= s2_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.skip  <= s2_nxt.skip;
      s2_r.clip  <= s2_nxt.clip;
      s2_r.rot   <= s2_nxt.rot;
      s2_r.color <= s2_nxt.color;
      s2_r.l     <= s2_nxt.l;
      s2_r.t     <= s2_nxt.t;
      s2_r.r     <= s2_nxt.r;
      s2_r.b     <= s2_nxt.b;
      s2_r.u0    <= s2_nxt.u0;
      s2_r.v0    <= s2_nxt.v0;
      s2_r.u1    <= s2_nxt.u1;
      s2_r.v1    <= s2_nxt.v1;
      s2_r.bx    <= s2_nxt.bx;
      s2_r.by    <= s2_nxt.by;
      s2_r.neg   <= s2_nxt.neg;
      s2_mag_r   <= s2_mag_nxt;
      s2_w_r     <= s1_w_r;
      s2_h_r     <= s1_h_r;
    end
  end

  // divider stages, side data rides alongside
  logic [NB-1:0] quo [4];
  for (genvar k = 0; k < 4; k++) begin : g_div
    ssuvr_div #(.NB(NB), .DB(CB)) u_div (
      .clk (clk),
      .en  (adv),
      .num (s2_mag_r[k]),
      .den ((k < 2) ? s2_w_r : s2_h_r),
      .quo (quo[k])
    );
  end

  side_t side_r [NB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) side_r[i].vld <= 1'b0;
    end else if (adv) begin
      side_r[0].vld <= s2_r.vld;
      for (int i = 1; i < NB; i++) side_r[i].vld <= side_r[i-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].skip  <= s2_r.skip;
      side_r[0].clip  <= s2_r.clip;
      side_r[0].rot   <= s2_r.rot;
      side_r[0].color <= s2_r.color;
      side_r[0].l     <= s2_r.l;
      side_r[0].t     <= s2_r.t;
      side_r[0].r     <= s2_r.r;
      side_r[0].b     <= s2_r.b;
      side_r[0].u0    <= s2_r.u0;
      side_r[0].v0    <= s2_r.v0;
      side_r[0].u1    <= s2_r.u1;
      side_r[0].v1    <= s2_r.v1;
      side_r[0].bx    <= s2_r.bx;
      side_r[0].by    <= s2_r.by;
      side_r[0].neg   <= s2_r.neg;
      for (int i = 1; i < NB; i++) begin
        side_r[i].skip  <= side_r[i-1].skip;
        side_r[i].clip  <= side_r[i-1].clip;
        side_r[i].rot   <= side_r[i-1].rot;
        side_r[i].color <= side_r[i-1].color;
        side_r[i].l     <= side_r[i-1].l;
        side_r[i].t     <= side_r[i-1].t;
        side_r[i].r     <= side_r[i-1].r;
        side_r[i].b     <= side_r[i-1].b;
        side_r[i].u0    <= side_r[i-1].u0;
        side_r[i].v0    <= side_r[i-1].v0;
        side_r[i].u1    <= side_r[i-1].u1;
        side_r[i].v1    <= side_r[i-1].v1;
        side_r[i].bx    <= side_r[i-1].bx;
        side_r[i].by    <= side_r[i-1].by;
        side_r[i].neg   <= side_r[i-1].neg;
      end
    end
  end

  // final stage: add base, saturate, route
  side_t         sd;
  logic [FB:0]   edge_v [4];
  logic          skip_nxt;
  logic signed [CB-1:0] l_nxt, t_nxt, r_nxt, b_nxt;
  logic [FB:0]   u0_nxt, v0_nxt, u1_nxt, v1_nxt;

  assign sd = side_r[NB-1];

  always_comb begin
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] one;
    one = SW'(1) <<< FB;
    for (int k = 0; k < 4; k++) begin
      qs  = sd.neg[k] ? -$signed({2'b00, quo[k]}) : $signed({2'b00, quo[k]});
      sum = $signed(SW'((k < 2) ? sd.bx : sd.by)) + qs;
      if (sum < 0) edge_v[k] = '0;
      else if (sum > one) edge_v[k] = one[FB:0];
      else edge_v[k] = sum[FB:0];
    end
    skip_nxt = sd.skip;
    l_nxt = sd.l;
    t_nxt = sd.t;
    r_nxt = sd.r;
    b_nxt = sd.b;
    if (!sd.clip) begin
      u0_nxt = sd.u0;
      v0_nxt = sd.v0;
      u1_nxt = sd.u1;
      v1_nxt = sd.v1;
    end else if (sd.rot) begin
      v0_nxt = edge_v[0];
      v1_nxt = edge_v[1];
      u0_nxt = edge_v[2];
      u1_nxt = edge_v[3];
    end else begin
      u0_nxt = edge_v[0];
      u1_nxt = edge_v[1];
      v0_nxt = edge_v[2];
      v1_nxt = edge_v[3];
    end
  end

  logic                 out_skipped_r, out_rotated_r;
  logic signed [CB-1:0] out_left_r, out_top_r, out_right_r, out_bottom_r;
  logic [FB:0]          out_u0_r, out_v0_r, out_u1_r, out_v1_r;
  logic [ssuvr_pkg::COLOR_W-1:0] out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sd.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_skipped_r <= skip_nxt;
      out_left_r    <= skip_nxt ? '0 : l_nxt;
      out_top_r     <= skip_nxt ? '0 : t_nxt;
      out_right_r   <= skip_nxt ? '0 : r_nxt;
      out_bottom_r  <= skip_nxt ? '0 : b_nxt;
      out_u0_r      <= skip_nxt ? '0 : u0_nxt;
      out_v0_r      <= skip_nxt ? '0 : v0_nxt;
      out_u1_r      <= skip_nxt ? '0 : u1_nxt;
      out_v1_r      <= skip_nxt ? '0 : v1_nxt;
      out_rotated_r <= skip_nxt ? 1'b0 : sd.rot;
      out_color_r   <= skip_nxt ? '0 : sd.color;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_skipped = out_skipped_r;
  assign out_left    = out_left_r;
  assign out_top     = out_top_r;
  assign out_right   = out_right_r;
  assign out_bottom  = out_bottom_r;
  assign out_u0      = out_u0_r;
  assign out_v0      = out_v0_r;
  assign out_u1      = out_u1_r;
  assign out_v1      = out_v1_r;
  assign out_rotated = out_rotated_r;
  assign out_color   = out_color_r;

endmodule

// ===== sv/ssuvr_chk.sv =====
module ssuvr_chk #(
  parameter int COORD_BITS   = 16,
  parameter int UV_FRAC_BITS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_skipped,
  input logic signed [COORD_BITS-1:0] out_left,
  input logic [UV_FRAC_BITS:0]        out_u0,
  input logic [UV_FRAC_BITS:0]        out_v1,
  input logic                         out_rotated
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left) && $stable(out_u0))
    else $error("result word changed while stalled");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_skipped |-> out_left == 0 && out_u0 == 0 && out_v1 == 0 && !out_rotated)
    else $error("rejected sprite carries nonzero fields");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sprite_scissor_uv_remap_core ssuvr_chk #(
  .COORD_BITS(COORD_BITS),
  .UV_FRAC_BITS(UV_FRAC_BITS)
) u_ssuvr_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_skipped (out_skipped),
  .out_left    (out_left),
  .out_u0      (out_u0),
  .out_v1      (out_v1),
  .out_rotated (out_rotated)
);
